### src/evt3_pkg.sv
// shared types and constants for the event stream decoder
`default_nettype none

package evt3_pkg;

  // stream word type codes, bits 15..12 of a word
  localparam logic [3:0] TYPE_Y      = 4'd0;
  localparam logic [3:0] TYPE_X      = 4'd2;
  localparam logic [3:0] TYPE_BASE_X = 4'd3;
  localparam logic [3:0] TYPE_VEC12  = 4'd4;
  localparam logic [3:0] TYPE_VEC8   = 4'd5;
  localparam logic [3:0] TYPE_TLOW   = 4'd6;
  localparam logic [3:0] TYPE_THIGH  = 4'd8;
  localparam logic [3:0] TYPE_IGN_A  = 4'd10;
  localparam logic [3:0] TYPE_IGN_B  = 4'd14;
  localparam logic [3:0] TYPE_IGN_C  = 4'd15;

  // result kind codes
  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // vector lengths in columns
  localparam logic [15:0] VEC12_LEN = 16'd12;
  localparam logic [15:0] VEC8_LEN  = 16'd8;

  // parameter defaults
  localparam int STAMP_BITS_DEF  = 48;
  localparam int WRAP_BITS_DEF   = 24;
  localparam int QUEUE_DEPTH_DEF = 4;

  // one queued command: a run of events over the set mask bits, or one error item
  typedef struct packed {
    logic        kind;
    logic [15:0] base;
    logic [11:0] mask;
    logic [10:0] row;
    logic        pol;
  } cmd_t;

  localparam int CMD_BITS = $bits(cmd_t);

endpackage

`default_nettype wire

### src/evt3_front.sv
// front end: accepts stream words, keeps decoder state, queues event runs and error items
`default_nettype none

module evt3_front
  import evt3_pkg::*;
#(
  parameter int STAMP_BITS = STAMP_BITS_DEF,
  parameter int WRAP_BITS  = WRAP_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [15:0]           word,
  input  wire logic                  q_full,
  output logic                       push,
  output cmd_t                       push_cmd,
  output logic [STAMP_BITS-1:0]      push_stamp
);

  localparam int UP_BITS   = WRAP_BITS + 13;
  localparam int FULL_BITS = UP_BITS + 12;

  logic [10:0]           row_held,      row_held_next;
  logic                  polarity_held, polarity_held_next;
  logic [15:0]           vector_base,   vector_base_next;
  logic [11:0]           low_field,     low_field_next;
  logic [11:0]           high_field,    high_field_next;
  logic [WRAP_BITS-1:0]  low_wraps,     low_wraps_next;
  logic [WRAP_BITS-1:0]  high_wraps,    high_wraps_next;
  logic [STAMP_BITS-1:0] stamp_held,    stamp_held_next;

  logic                  take;
  logic                  want_push;
  logic                  time_upd;
  logic [3:0]            wtype;
  logic [11:0]           field;
  logic [UP_BITS-1:0]    upper;
  logic [FULL_BITS-1:0]  full_stamp;
  cmd_t                  cmd;
  logic [STAMP_BITS-1:0] cmd_stamp;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;
  assign wtype    = word[15:12];
  assign field    = word[11:0];

  // word classification and next decoder state
  always_comb begin
    row_held_next      = row_held;
    polarity_held_next = polarity_held;
    vector_base_next   = vector_base;
    low_field_next     = low_field;
    high_field_next    = high_field;
    low_wraps_next     = low_wraps;
    high_wraps_next    = high_wraps;
    want_push          = 1'b0;
    time_upd           = 1'b0;
    cmd                = '0;
    cmd_stamp          = stamp_held;
    cmd.kind           = KIND_EVENT;
    cmd.base           = vector_base;
    cmd.row            = row_held;
    cmd.pol            = polarity_held;
    unique case (wtype)
      TYPE_Y: begin
        row_held_next = word[10:0];
      end
      TYPE_X: begin
        polarity_held_next = word[11];
        want_push          = 1'b1;
        cmd.base           = {5'b0, word[10:0]};
        cmd.mask           = 12'h001;
        cmd.pol            = word[11];
      end
      TYPE_BASE_X: begin
        polarity_held_next = word[11];
        vector_base_next   = {5'b0, word[10:0]};
      end
      TYPE_VEC12: begin
        cmd.mask         = word[11:0];
        want_push        = (word[11:0] != 12'h000);
        vector_base_next = vector_base + VEC12_LEN;
      end
      TYPE_VEC8: begin
        cmd.mask         = {4'b0, word[7:0]};
        want_push        = (word[7:0] != 8'h00);
        vector_base_next = vector_base + VEC8_LEN;
      end
      TYPE_TLOW: begin
        if (field < low_field) begin
          low_wraps_next = low_wraps + WRAP_BITS'(1);
        end
        low_field_next = field;
        time_upd       = 1'b1;
      end
      TYPE_THIGH: begin
        if (field < high_field) begin
          high_wraps_next = high_wraps + WRAP_BITS'(1);
        end
        high_field_next = field;
        time_upd        = 1'b1;
      end
      TYPE_IGN_A, TYPE_IGN_B, TYPE_IGN_C: begin
      end
      default: begin
        want_push = 1'b1;
        cmd.kind  = KIND_ERROR;
        cmd.base  = '0;
        cmd.mask  = 12'h001;
        cmd.row   = '0;
        cmd.pol   = 1'b0;
        cmd_stamp = '0;
      end
    endcase
  end

  // timestamp rebuild: low field sits below a sum shifted by twelve
  always_comb begin
    upper = {1'b0, high_wraps_next, 12'b0}
          + UP_BITS'(high_field_next)
          + UP_BITS'(low_wraps_next);
    full_stamp      = {upper, low_field_next};
    stamp_held_next = time_upd ? STAMP_BITS'(full_stamp) : stamp_held;
  end

  // decoder state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_held      <= '0;
      polarity_held <= 1'b0;
      vector_base   <= '0;
      low_field     <= '0;
      high_field    <= '0;
      low_wraps     <= '0;
      high_wraps    <= '0;
      stamp_held    <= '0;
    end else if (take) begin
      row_held      <= row_held_next;
      polarity_held <= polarity_held_next;
      vector_base   <= vector_base_next;
      low_field     <= low_field_next;
      high_field    <= high_field_next;
      low_wraps     <= low_wraps_next;
      high_wraps    <= high_wraps_next;
      stamp_held    <= stamp_held_next;
    end
  end

  assign push       = take && want_push;
  assign push_cmd   = cmd;
  assign push_stamp = cmd_stamp;

endmodule

`default_nettype wire

### src/evt3_fifo.sv
// short command queue between front and back end
`default_nettype none

module evt3_fifo
  import evt3_pkg::*;
#(
  parameter int WIDTH = CMD_BITS + STAMP_BITS_DEF,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  output logic                  q_valid,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      q_data
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == FULL_CNT);
  assign q_valid = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;
  assign q_data  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

### src/evt3_back.sv
// back end: expands queued runs into items, one per cycle unless stalled
`default_nettype none

module evt3_back
  import evt3_pkg::*;
#(
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_valid,
  input  wire cmd_t                  q_cmd,
  input  wire logic [STAMP_BITS-1:0] q_stamp,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       kind,
  output logic [15:0]                x_addr,
  output logic [10:0]                y_addr,
  output logic                       polarity,
  output logic [STAMP_BITS-1:0]      stamp,
  output logic                       last_of_run
);

  logic                  cur_valid;
  cmd_t                  cur;
  logic [STAMP_BITS-1:0] cur_stamp;
  logic                  out_load;
  logic                  fire;
  logic [3:0]            idx;
  logic [11:0]           rest;
  logic                  last;

  assign out_load = !out_valid || !out_stall;
  assign fire     = cur_valid && out_load;

  // lowest set mask bit and what remains after it
  always_comb begin
    idx = '0;
    for (int k = 11; k >= 0; k--) begin
      if (cur.mask[k]) begin
        idx = 4'(k);
      end
    end
    rest = cur.mask & (cur.mask - 12'd1);
    last = (rest == 12'd0);
  end

  assign pop = q_valid && (!cur_valid || (fire && last));

  // run control
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (fire && last) begin
        cur_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= fire;
      end
    end
  end

  // current run payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cur       <= q_cmd;
      cur_stamp <= q_stamp;
    end else if (fire) begin
      cur.mask <= rest;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (fire) begin
      kind        <= cur.kind;
      x_addr      <= cur.base + {12'b0, idx};
      y_addr      <= cur.row;
      polarity    <= cur.pol;
      stamp       <= cur_stamp;
      last_of_run <= last;
    end
  end

endmodule

`default_nettype wire

### src/evt3_event_stream_decoder_core.sv
// evt3 event stream decoder, top level
// a word's first result passes a queue slot, the current run and the output register
// throughput: one word per cycle into the front end while in_stall is low; the back end
//   emits one result per cycle unless stalled, one for each set bit of a vector mask
// in_stall rises only when the command queue (4 entries by default) is full
// reset: synchronous, clears decoder state, queue and output valid
`default_nettype none

module evt3_event_stream_decoder_core
  import evt3_pkg::*;
#(
  parameter int STAMP_BITS  = STAMP_BITS_DEF,
  parameter int WRAP_BITS   = WRAP_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [15:0]           word,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       kind,
  output logic [15:0]                x_addr,
  output logic [10:0]                y_addr,
  output logic                       polarity,
  output logic [STAMP_BITS-1:0]      stamp,
  output logic                       last_of_run
);

  localparam int Q_WIDTH = CMD_BITS + STAMP_BITS;

  logic                  push;
  cmd_t                  push_cmd;
  logic [STAMP_BITS-1:0] push_stamp;
  logic                  q_full;
  logic                  q_valid;
  logic                  pop;
  logic [Q_WIDTH-1:0]    q_data;
  cmd_t                  q_cmd;
  logic [STAMP_BITS-1:0] q_stamp;

  // front end
  evt3_front #(
    .STAMP_BITS (STAMP_BITS),
    .WRAP_BITS  (WRAP_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .word       (word),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_stamp (push_stamp)
  );

  // command queue
  evt3_fifo #(
    .WIDTH (Q_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_cmd, push_stamp}),
    .full      (q_full),
    .q_valid   (q_valid),
    .pop       (pop),
    .q_data    (q_data)
  );

  assign q_cmd   = cmd_t'(q_data[Q_WIDTH-1:STAMP_BITS]);
  assign q_stamp = q_data[STAMP_BITS-1:0];

  // back end
  evt3_back #(
    .STAMP_BITS (STAMP_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_stamp     (q_stamp),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .x_addr      (x_addr),
    .y_addr      (y_addr),
    .polarity    (polarity),
    .stamp       (stamp),
    .last_of_run (last_of_run)
  );

`ifndef SYNTHESIS
  // an error item is a lone result with cleared fields
  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_ERROR) |->
      last_of_run && (x_addr == 16'd0) && (y_addr == 11'd0) && (stamp == '0))
    else $error("error item with nonzero fields");

  // an accepted column word always queues a run
  a_x_queues: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (word[15:12] == TYPE_X) |-> push)
    else $error("column word did not queue an item");

  // the back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");

  // a queue that was full and not popped stays full
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    q_full && !pop |=> q_full)
    else $error("queue lost an entry");
`endif

endmodule

`default_nettype wire

### test/evt3_event_stream_decoder_core_tb.sv
// self-checking testbench for the evt3 event stream decoder core
module evt3_event_stream_decoder_core_tb;
  import evt3_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB = STAMP_BITS_DEF;
  localparam int WB = WRAP_BITS_DEF;
  // cycles with no item accepted on either side before the run is declared hung
  localparam int HANG_LIMIT = 1000;
  // cycles to keep watching the outputs once nothing is expected
  localparam int TAIL_CYCLES = 8;
  // word types the decoder does not know, four bits each
  localparam logic [23:0] UNKNOWN_TYPES = {4'd13, 4'd12, 4'd11, 4'd9, 4'd7, 4'd1};

  typedef struct {
    logic          kind;
    logic [15:0]   x;
    logic [10:0]   y;
    logic          pol;
    logic [SB-1:0] stamp;
    logic          last;
  } event_rec_t;

  logic          clk;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [15:0]   word = 16'h0000;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic          kind;
  logic [15:0]   x_addr;
  logic [10:0]   y_addr;
  logic          polarity;
  logic [SB-1:0] stamp;
  logic          last_of_run;

  // decoder state as predicted
  logic [10:0]   held_row = '0;
  logic          held_pol = 1'b0;
  logic [SB-1:0] held_stamp = '0;
  logic [15:0]   next_column = '0;
  logic [11:0]   low_time = '0;
  logic [11:0]   high_time = '0;
  logic [WB-1:0] low_wraps = '0;
  logic [WB-1:0] high_wraps = '0;

  event_rec_t pending_events[$];
  event_rec_t want;

  bit send_idle_on = 1'b0;
  bit stall_on = 1'b0;
  int stall_left = 0;
  int stall_gap;
  int error_count = 0;
  int words_sent = 0;
  int events_seen = 0;
  int type_errors_seen = 0;
  int quiet_cycles = 0;

  evt3_event_stream_decoder_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .word(word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .x_addr(x_addr),
    .y_addr(y_addr),
    .polarity(polarity),
    .stamp(stamp),
    .last_of_run(last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [SB-1:0] build_stamp();
    logic [63:0] t;
    t = (64'(high_wraps) << 24) + ((64'(high_time) + 64'(low_wraps)) << 12) + 64'(low_time);
    return t[SB-1:0];
  endfunction

  task automatic push_event(input logic k, input logic [15:0] x, input logic [10:0] y,
                            input logic p, input logic [SB-1:0] t, input logic last);
    event_rec_t rec;
    rec.kind = k;
    rec.x = x;
    rec.y = y;
    rec.pol = p;
    rec.stamp = t;
    rec.last = last;
    pending_events.push_back(rec);
  endtask

  // predict the results of one accepted word and advance the held state
  task automatic decode_word(input logic [15:0] w);
    logic [11:0] mask;
    logic [15:0] len;
    int top;
    case (w[15:12])
      TYPE_Y: held_row = w[10:0];
      TYPE_X: begin
        held_pol = w[11];
        push_event(KIND_EVENT, {5'b0, w[10:0]}, held_row, held_pol, held_stamp, 1'b1);
      end
      TYPE_BASE_X: begin
        held_pol = w[11];
        next_column = {5'b0, w[10:0]};
      end
      TYPE_VEC12, TYPE_VEC8: begin
        if (w[15:12] == TYPE_VEC12) begin
          mask = w[11:0];
          len = VEC12_LEN;
        end else begin
          mask = {4'b0, w[7:0]};
          len = VEC8_LEN;
        end
        top = -1;
        for (int k = 0; k < 12; k++) if (mask[k]) top = k;
        for (int k = 0; k < 12; k++) begin
          if (mask[k])
            push_event(KIND_EVENT, next_column + 16'(k), held_row, held_pol, held_stamp,
                       k == top);
        end
        next_column = next_column + len;
      end
      TYPE_TLOW: begin
        if (w[11:0] < low_time) low_wraps = low_wraps + 1'b1;
        low_time = w[11:0];
        held_stamp = build_stamp();
      end
      TYPE_THIGH: begin
        if (w[11:0] < high_time) high_wraps = high_wraps + 1'b1;
        high_time = w[11:0];
        held_stamp = build_stamp();
      end
      TYPE_IGN_A, TYPE_IGN_B, TYPE_IGN_C: ;
      default: push_event(KIND_ERROR, '0, '0, 1'b0, '0, 1'b1);
    endcase
  endtask

  // offer one item and wait until it is taken
  task automatic send_word(input logic [15:0] w);
    int gap;
    gap = send_idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_word(w);
    words_sent++;
  endtask

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      error_count++;
    end
  endtask

  // output backpressure: random stall bursts, with out_stall dropped between bursts
  always @(posedge clk) begin
    if (rst || !stall_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      stall_gap = pick_gap();
      if (stall_gap != 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_gap - 1;
      end
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $error("result with nothing expected: kind %0b x 0x%0h y 0x%0h", kind, x_addr, y_addr);
        error_count++;
      end else begin
        want = pending_events.pop_front();
        check_field("kind", want.kind, kind);
        check_field("x_addr", want.x, x_addr);
        check_field("y_addr", want.y, y_addr);
        check_field("polarity", want.pol, polarity);
        check_field("stamp", want.stamp, stamp);
        check_field("last_of_run", want.last, last_of_run);
        if (want.kind == KIND_ERROR) type_errors_seen++;
        else events_seen++;
      end
    end
  end

  // hang detection
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // row, column and polarity extremes
  task automatic test_addresses();
    send_word({TYPE_Y, 12'hFFF});
    send_word({TYPE_X, 12'hFFF});
    send_word({TYPE_Y, 12'h000});
    send_word({TYPE_X, 12'h000});
  endtask

  // full and empty masks on both vector lengths, a sparse mask on the twelve-column one
  task automatic test_vectors();
    send_word({TYPE_BASE_X, 12'hFFF});
    send_word({TYPE_VEC12, 12'hFFF});
    send_word({TYPE_VEC8, 12'hFFF});
    send_word({TYPE_VEC12, 12'h000});
    send_word({TYPE_VEC8, 12'hF00});
    send_word({TYPE_VEC12, 12'h801});
  endtask

  // both time fields at their extremes, each wrapping once
  task automatic test_timestamps();
    send_word({TYPE_TLOW, 12'hFFF});
    send_word({TYPE_THIGH, 12'hFFF});
    send_word({TYPE_X, 12'h123});
    send_word({TYPE_TLOW, 12'h000});
    send_word({TYPE_THIGH, 12'h000});
    send_word({TYPE_X, 12'h456});
  endtask

  // ignored types give nothing, unknown types give one error result
  task automatic test_ignored_and_unknown();
    send_word({TYPE_IGN_A, 12'h123});
    send_word({TYPE_IGN_B, 12'hFFF});
    send_word({TYPE_IGN_C, 12'h000});
    send_word({UNKNOWN_TYPES[3:0], 12'hFFF});
    send_word({UNKNOWN_TYPES[7:4], 12'h000});
    send_word({UNKNOWN_TYPES[11:8], 12'hABC});
    send_word({UNKNOWN_TYPES[15:12], 12'h555});
    send_word({UNKNOWN_TYPES[19:16], 12'hFFF});
    send_word({UNKNOWN_TYPES[23:20], 12'h001});
  endtask

  // vector runs that carry the column past the eleven bits of a base word
  task automatic test_column_carry();
    send_word({TYPE_BASE_X, 12'h7F8});
    send_word({TYPE_VEC8, 12'h0FF});
    send_word({TYPE_VEC12, 12'hFFF});
    send_word({TYPE_VEC8, 12'h081});
  endtask

  // mostly well-formed packets with random content, some noise
  task automatic test_random_stream(input int n_words);
    int target;
    int start;
    int run;
    int nvec;
    int sel;
    logic [11:0] mask;
    start = words_sent;
    target = words_sent + n_words;
    while (words_sent < target) begin
      // idle on both sides, except for a stretch in the middle
      send_idle_on = ((words_sent - start) / 100) != 1;
      stall_on = send_idle_on;
      if ($urandom_range(0, 99) < 80) begin
        if ($urandom_range(0, 3) == 0) send_word({TYPE_THIGH, 12'($urandom)});
        send_word({TYPE_TLOW, 12'($urandom)});
        send_word({TYPE_Y, 12'($urandom)});
        run = $urandom_range(1, 4);
        for (int i = 0; i < run; i++) begin
          if ($urandom_range(0, 1) == 0) begin
            send_word({TYPE_X, 12'($urandom)});
          end else begin
            send_word({TYPE_BASE_X, 12'($urandom)});
            nvec = $urandom_range(1, 3);
            for (int j = 0; j < nvec; j++) begin
              sel = $urandom_range(0, 3);
              if (sel == 0) mask = 12'hFFF;
              else if (sel == 1) mask = 12'(1 << $urandom_range(0, 11));
              else mask = 12'($urandom);
              if ($urandom_range(0, 1) == 0) send_word({TYPE_VEC12, mask});
              else send_word({TYPE_VEC8, 4'($urandom), mask[7:0]});
            end
          end
        end
      end else begin
        sel = $urandom_range(0, 2);
        if (sel == 0) send_word(16'($urandom));
        else if (sel == 1) send_word({UNKNOWN_TYPES[4 * $urandom_range(0, 5) +: 4],
                                      12'($urandom)});
        else send_word({TYPE_IGN_B, 12'($urandom)});
      end
    end
    send_idle_on = 1'b0;
    stall_on = 1'b0;
  endtask

  // reset, directed tests, column carry, random stream, then drain
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_addresses();
    test_vectors();
    test_timestamps();
    test_ignored_and_unknown();
    test_column_carry();
    test_random_stream(300);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d words giving %0d events and %0d type error results",
             words_sent, events_seen, type_errors_seen);
    $display("with address, vector, timestamp wrap, ignored, unknown and column carry cases");
    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sim.f
src/evt3_pkg.sv
src/evt3_front.sv
src/evt3_fifo.sv
src/evt3_back.sv
src/evt3_event_stream_decoder_core.sv
test/evt3_event_stream_decoder_core_tb.sv
